// ----- rtl/dtps_pkg.sv -----
// shared constants and types for the drying cabinet plant step
`default_nettype none
package dtps_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [16:0] Q_ONE = 17'h10000;
  localparam logic [47:0] RATE_CAP = 48'h8000_0000_0000;
  localparam logic signed [22:0] AMBIENT_RESET = 23'sd1310720;
  localparam logic [9:0] SPEEDUP_RESET = 10'd1;
  localparam logic [10:0] DIVISOR = 11'd1000;

  // serial unit widths
  localparam int MULA_W = 64;
  localparam int MULB_W = 33;
  localparam int DIV_W = 64;

  // register indexes
  localparam logic [2:0] REG_HEATER_GAIN = 3'd0;
  localparam logic [2:0] REG_SOLAR_GAIN = 3'd1;
  localparam logic [2:0] REG_BASE_LOSS = 3'd2;
  localparam logic [2:0] REG_FAN_EXTRA_LOSS = 3'd3;
  localparam logic [2:0] REG_DRYING_RATE = 3'd4;
  localparam logic [2:0] REG_AMBIENT_TEMP = 3'd5;
  localparam logic [2:0] REG_TIME_SPEEDUP = 3'd6;

  typedef struct packed {
    logic start;
    logic [MULA_W-1:0] a;
    logic [MULB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic start;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

endpackage
`default_nettype wire

// ----- rtl/dtps_mul.sv -----
// bit-serial shift-add multiplier, one multiplier bit per cycle
`default_nettype none
module dtps_mul
  import dtps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mul_req_t          req,
  output logic                   done,
  output logic [MULA_W-1:0]      prod
);

  localparam int CNT_W = $clog2(MULB_W + 1);

  logic              run;
  logic [CNT_W-1:0]  cnt;
  logic [MULA_W-1:0] mcand;
  logic [MULB_W-1:0] mplier;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= CNT_W'(MULB_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: add shifted multiplicand on each set multiplier bit
  always_ff @(posedge clk) begin
    if (req.start) begin
      prod <= '0;
      mcand <= req.a;
      mplier <= req.b;
    end else if (run) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand <= {mcand[MULA_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[MULB_W-1:1]};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dtps_div.sv -----
// bit-serial restoring divider by the constant one thousand
`default_nettype none
module dtps_div
  import dtps_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire div_req_t         req,
  output logic                  done,
  output logic [DIV_W-1:0]      quot
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [9:0]       rem;
  logic [10:0]      trial;

  assign trial = {rem, quot[DIV_W-1]};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= CNT_W'(DIV_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top, quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quot <= req.dividend;
    end else if (run) begin
      if (trial >= DIVISOR) begin
        rem <= 10'(trial - DIVISOR);
        quot <= {quot[DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[9:0];
        quot <= {quot[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dryer_thermal_plant_step.sv -----
// drying cabinet thermal plant step, top level with sub-step sequencer
//
//  channel  signals                    direction  payload
//  in       in_valid / in_ready        to block   action, step_ms, flags, solar_level
//  out      out_valid / out_ready      from block cabinet_temp_out, top_temp_out,
//                                                 moisture_out
//  cfg      cfg_we                     to block   cfg_index, cfg_data
//
// a tick runs ceil(step_ms * time_speedup / MAX_SUBSTEP_MS) sub-steps in the shared serial
// multiplier and divider. a full sub-step runs six products and two quotients; the last
// product is skipped when the moisture is wiped out, and the drying part (three products
// and one quotient) when the cabinet is not above ambient.
// a tick's result is registered at the output after its last sub-step, a plant reset
// transaction goes straight to the output state S_TOP; a held result stalls the sequencer.
// rst is synchronous and restores registers and plant state to their defaults.
`default_nettype none
module dryer_thermal_plant_step
  import dtps_pkg::*;
#(
  parameter int MAX_SUBSTEP_MS = 5000
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               action,
  input  wire logic [13:0]        step_ms,
  input  wire logic               heater_on,
  input  wire logic               intake_fan_on,
  input  wire logic               stack_fan_on,
  input  wire logic [20:0]        solar_level,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      cabinet_temp_out,
  output logic signed [31:0]      top_temp_out,
  output logic [16:0]             moisture_out,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [30:0]        cfg_data
);

  localparam int HW = $clog2(MAX_SUBSTEP_MS + 1);
  localparam logic [23:0] MAX_MS = 24'(MAX_SUBSTEP_MS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SUB   = 4'd1;
  localparam logic [3:0] S_MSOL  = 4'd2;
  localparam logic [3:0] S_MLOSS = 4'd3;
  localparam logic [3:0] S_MRH   = 4'd4;
  localparam logic [3:0] S_DRH   = 4'd5;
  localparam logic [3:0] S_DRV   = 4'd6;
  localparam logic [3:0] S_MDRY  = 4'd7;
  localparam logic [3:0] S_MFH   = 4'd8;
  localparam logic [3:0] S_DF    = 4'd9;
  localparam logic [3:0] S_MM    = 4'd10;
  localparam logic [3:0] S_TOP   = 4'd11;

  // configuration registers
  logic [30:0]        heater_gain, solar_gain, base_loss, fan_extra_loss, drying_rate;
  logic signed [22:0] ambient_temp;
  logic [9:0]         time_speedup;

  // plant state and per-transaction context
  logic signed [31:0] cabinet_temp;
  logic [16:0]        moisture_left;
  logic [3:0]         state;
  logic [23:0]        total_ms;
  logic [HW-1:0]      h;
  logic               heat_l, intake_l, stack_l;
  logic [20:0]        solar_l;
  logic [35:0]        solar_term;
  logic               rate_neg;

  mul_req_t           mreq;
  div_req_t           dreq;
  logic               mdone, ddone;
  logic [MULA_W-1:0]  prod;
  logic [DIV_W-1:0]   quot;

  dtps_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .done(mdone), .prod(prod));
  dtps_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quot(quot));

  assign in_ready = (state == S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      heater_gain <= '0;
      solar_gain <= '0;
      base_loss <= '0;
      fan_extra_loss <= '0;
      drying_rate <= '0;
      ambient_temp <= AMBIENT_RESET;
      time_speedup <= SPEEDUP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEATER_GAIN:    heater_gain <= cfg_data;
        REG_SOLAR_GAIN:     solar_gain <= cfg_data;
        REG_BASE_LOSS:      base_loss <= cfg_data;
        REG_FAN_EXTRA_LOSS: fan_extra_loss <= cfg_data;
        REG_DRYING_RATE:    drying_rate <= cfg_data;
        REG_AMBIENT_TEMP:   ambient_temp <= cfg_data[22:0];
        REG_TIME_SPEEDUP:   time_speedup <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // datapath helpers
  logic [31:0]        coef;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [47:0]        prod_q;
  logic [47:0]        prod_qc;
  logic signed [50:0] rate_raw;
  logic signed [50:0] rate_c;
  logic [47:0]        rate_mag;
  logic signed [53:0] cab_sum;
  logic signed [31:0] cab_sat;
  logic [DIV_W-1:0]   f_val;
  logic signed [34:0] top_raw;
  logic signed [31:0] top_sat;
  logic [HW-1:0]      h_next;

  always_comb begin
    coef = {1'b0, base_loss} + (stack_l ? {1'b0, fan_extra_loss} : 32'd0);
    diff = 33'(cabinet_temp) - 33'(ambient_temp);
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    prod_q = prod[63:16];
    prod_qc = (prod_q > RATE_CAP) ? RATE_CAP : prod_q;
    // net heating rate, loss sign follows the temperature difference
    rate_raw = $signed({20'd0, heat_l ? heater_gain : 31'd0})
             + $signed({15'd0, solar_term})
             - (diff[32] ? -$signed({3'd0, prod_qc}) : $signed({3'd0, prod_qc}));
    if (rate_raw > $signed({3'd0, RATE_CAP})) begin
      rate_c = $signed({3'd0, RATE_CAP});
    end else if (rate_raw < -$signed({3'd0, RATE_CAP})) begin
      rate_c = -$signed({3'd0, RATE_CAP});
    end else begin
      rate_c = rate_raw;
    end
    rate_mag = rate_c[50] ? 48'(-rate_c) : 48'(rate_c);
    // temperature update with int32 saturation
    cab_sum = 54'(cabinet_temp) + (rate_neg ? -$signed({1'b0, quot[52:0]})
                                             : $signed({1'b0, quot[52:0]}));
    if (cab_sum > 54'sd2147483647) begin
      cab_sat = 32'sh7FFF_FFFF;
    end else if (cab_sum < -54'sd2147483648) begin
      cab_sat = 32'sh8000_0000;
    end else begin
      cab_sat = 32'(cab_sum);
    end
    f_val = stack_l ? quot : {1'b0, quot[DIV_W-1:1]};
    // top reading: stratification and evaporative cooling
    top_raw = 35'(cabinet_temp) - (stack_l ? 35'sd131072 : 35'sd262144)
            - $signed({1'b0, 19'({moisture_left, 1'b0}) + 19'(moisture_left)});
    if (top_raw < -35'sd2147483648) begin
      top_sat = 32'sh8000_0000;
    end else begin
      top_sat = 32'(top_raw);
    end
    h_next = (total_ms < MAX_MS) ? total_ms[HW-1:0] : MAX_MS[HW-1:0];
  end

  // serial unit launches, taken on the edge that leaves each state
  always_comb begin
    mreq = '{start: 1'b0, a: '0, b: '0};
    dreq = '{start: 1'b0, dividend: prod};
    case (state)
      S_SUB: begin
        if (total_ms != '0) begin
          mreq = '{start: 1'b1, a: MULA_W'(solar_gain), b: MULB_W'(solar_l)};
        end
      end
      S_MSOL: begin
        if (mdone) begin
          mreq = '{start: 1'b1, a: MULA_W'(coef), b: diff_mag};
        end
      end
      S_MLOSS: begin
        if (mdone) begin
          mreq = '{start: 1'b1, a: MULA_W'(rate_mag), b: MULB_W'(h)};
        end
      end
      S_MRH: begin
        if (mdone) begin
          dreq.start = 1'b1;
        end
      end
      S_DRV: begin
        if (!diff[32] && diff != '0) begin
          mreq = '{start: 1'b1, a: MULA_W'(drying_rate), b: diff_mag};
        end
      end
      S_MDRY: begin
        if (mdone) begin
          mreq = '{start: 1'b1, a: MULA_W'(prod_qc), b: MULB_W'(h)};
        end
      end
      S_MFH: begin
        if (mdone) begin
          dreq.start = 1'b1;
        end
      end
      S_DF: begin
        if (ddone && f_val < DIV_W'(Q_ONE)) begin
          mreq = '{start: 1'b1, a: f_val, b: MULB_W'(moisture_left)};
        end
      end
      default: ;
    endcase
  end

  // sub-step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      cabinet_temp <= 32'(AMBIENT_RESET);
      moisture_left <= Q_ONE;
    end else begin
      if (out_valid && out_ready && state != S_TOP) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            heat_l <= heater_on;
            intake_l <= intake_fan_on;
            solar_l <= solar_level;
            total_ms <= 24'(step_ms * time_speedup);
            if (action) begin
              cabinet_temp <= 32'(ambient_temp);
              moisture_left <= Q_ONE;
              stack_l <= 1'b0;
              state <= S_TOP;
            end else begin
              stack_l <= stack_fan_on;
              state <= S_SUB;
            end
          end
        end
        S_SUB: begin
          if (total_ms == '0) begin
            state <= S_TOP;
          end else begin
            h <= h_next;
            total_ms <= total_ms - 24'(h_next);
            state <= S_MSOL;
          end
        end
        S_MSOL: begin
          if (mdone) begin
            solar_term <= intake_l ? prod[51:16] : 36'd0;
            state <= S_MLOSS;
          end
        end
        S_MLOSS: begin
          if (mdone) begin
            rate_neg <= rate_c[50];
            state <= S_MRH;
          end
        end
        S_MRH: begin
          if (mdone) begin
            state <= S_DRH;
          end
        end
        S_DRH: begin
          if (ddone) begin
            cabinet_temp <= cab_sat;
            state <= S_DRV;
          end
        end
        S_DRV: begin
          if (!diff[32] && diff != '0) begin
            state <= S_MDRY;
          end else begin
            state <= S_SUB;
          end
        end
        S_MDRY: begin
          if (mdone) begin
            state <= S_MFH;
          end
        end
        S_MFH: begin
          if (mdone) begin
            state <= S_DF;
          end
        end
        S_DF: begin
          if (ddone) begin
            if (f_val >= DIV_W'(Q_ONE)) begin
              moisture_left <= '0;
              state <= S_SUB;
            end else begin
              state <= S_MM;
            end
          end
        end
        S_MM: begin
          if (mdone) begin
            moisture_left <= moisture_left - prod[32:16];
            state <= S_SUB;
          end
        end
        S_TOP: begin
          if (!out_valid || out_ready) begin
            cabinet_temp_out <= cabinet_temp;
            top_temp_out <= top_sat;
            moisture_out <= moisture_left;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dtps_check.sv -----
// port-level checks for the plant step and their binding
`default_nettype none
module dtps_check (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] cabinet_temp_out,
  input wire logic signed [31:0] top_temp_out,
  input wire logic [16:0]        moisture_out
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cabinet_temp_out))
    else $error("result changed while stalled");

  // moisture never exceeds full
  a_moist_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> moisture_out <= 17'h10000)
    else $error("moisture out of range");

  // one transaction in work at a time
  a_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // top reading never above cabinet reading
  a_top_le: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> top_temp_out <= cabinet_temp_out)
    else $error("top temperature above cabinet");

endmodule

bind dryer_thermal_plant_step dtps_check u_check (.*);
`default_nettype wire

// ----- tb/sv/tb_plant_checker.sv -----
// transaction monitor, plant predictor and result comparison for the plant step block
`timescale 1ns / 100ps
module tb_plant_checker
  import dtps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic               action,
  input  wire logic [13:0]        step_ms,
  input  wire logic               heater_on,
  input  wire logic               intake_fan_on,
  input  wire logic               stack_fan_on,
  input  wire logic [20:0]        solar_level,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [31:0] cabinet_temp_out,
  input  wire logic signed [31:0] top_temp_out,
  input  wire logic [16:0]        moisture_out,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [30:0]        cfg_data,
  output int                      mismatches,
  output int                      outstanding
);

  localparam int SUBSTEP_MS = 5000;
  localparam longint unsigned CAP = 64'h0000_8000_0000_0000;

  typedef struct {
    logic signed [31:0] cabinet;
    logic signed [31:0] top;
    logic [16:0]        moisture;
  } plant_obs_t;

  plant_obs_t plant_q[$];

  // shadow registers and plant state
  longint unsigned heater_gain, solar_gain, base_loss, fan_loss, dry_rate;
  longint          ambient;
  longint unsigned speedup;
  longint          cab_temp;
  longint          moist;

  assign outstanding = plant_q.size();

  // QF product of magnitudes, truncated and capped
  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> FRAC_BITS;
    return (p > {64'd0, CAP}) ? CAP : p[63:0];
  endfunction

  function automatic longint qmul_signed(longint unsigned coef, longint x);
    longint unsigned mag;
    longint r;
    mag = (x < 0) ? longint'(-x) : longint'(x);
    r = longint'(qmul(coef, mag));
    return (x < 0) ? -r : r;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // euler sub-steps over the scaled tick length
  function automatic void run_plant(longint unsigned total, logic heat, logic intake,
                                    logic stack, longint unsigned solar);
    longint unsigned h, coef, f;
    longint rate, drv;
    while (total > 0) begin
      h = (total < SUBSTEP_MS) ? total : SUBSTEP_MS;
      total -= h;
      rate = 0;
      if (heat) rate += longint'(heater_gain);
      if (intake) rate += longint'(qmul(solar_gain, solar));
      coef = base_loss + (stack ? fan_loss : 64'd0);
      rate -= qmul_signed(coef, cab_temp - ambient);
      if (rate > longint'(CAP)) rate = longint'(CAP);
      if (rate < -longint'(CAP)) rate = -longint'(CAP);
      cab_temp = clamp32(cab_temp + rate * longint'(h) / 64'sd1000);
      drv = cab_temp - ambient;
      if (drv > 0) begin
        f = qmul(dry_rate, longint'(drv)) * h / 64'd1000;
        if (!stack) f = f >> 1;
        if (f >= 64'd65536) moist = 0;
        else moist -= longint'((f * longint'(moist)) >> FRAC_BITS);
        if (moist < 0) moist = 0;
      end
    end
  endfunction

  function automatic plant_obs_t plant_tick(logic act, logic [13:0] ms, logic heat,
                                            logic intake, logic stack, logic [20:0] solar);
    plant_obs_t o;
    longint strat;
    if (act) begin
      cab_temp = ambient;
      moist = 65536;
      stack = 1'b0;
    end else begin
      run_plant(longint'(ms) * speedup, heat, intake, stack, longint'(solar));
    end
    strat = stack ? 64'sd131072 : 64'sd262144;
    o.cabinet = cab_temp[31:0];
    o.top = 32'(clamp32(cab_temp - strat - 3 * moist));
    o.moisture = moist[16:0];
    return o;
  endfunction

  always @(posedge clk) begin
    plant_obs_t want;
    if (rst) begin
      heater_gain = 0;
      solar_gain = 0;
      base_loss = 0;
      fan_loss = 0;
      dry_rate = 0;
      ambient = 1310720;
      speedup = 1;
      cab_temp = 1310720;
      moist = 65536;
      mismatches <= 0;
      plant_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_HEATER_GAIN:    heater_gain = 64'(cfg_data);
          REG_SOLAR_GAIN:     solar_gain = 64'(cfg_data);
          REG_BASE_LOSS:      base_loss = 64'(cfg_data);
          REG_FAN_EXTRA_LOSS: fan_loss = 64'(cfg_data);
          REG_DRYING_RATE:    dry_rate = 64'(cfg_data);
          REG_AMBIENT_TEMP:   ambient = longint'(signed'(cfg_data[22:0]));
          REG_TIME_SPEEDUP:   speedup = 64'(cfg_data[9:0]);
          default: ;
        endcase
      end
      // input transaction
      if (in_valid && in_ready)
        plant_q.push_back(plant_tick(action, step_ms, heater_on, intake_fan_on,
                                     stack_fan_on, solar_level));
      // output transaction
      if (out_valid && out_ready) begin
        if (plant_q.size() == 0) begin
          $display("%0t: unexpected result cabinet %0d top %0d moisture %0d", $time,
                   cabinet_temp_out, top_temp_out, moisture_out);
          mismatches <= mismatches + 1;
        end else begin
          want = plant_q.pop_front();
          if (want.cabinet !== cabinet_temp_out || want.top !== top_temp_out ||
              want.moisture !== moisture_out) begin
            $display("%0t: cabinet exp %0d got %0d, top exp %0d got %0d, moist exp %0d got %0d",
                     $time, want.cabinet, cabinet_temp_out, want.top, top_temp_out,
                     want.moisture, moisture_out);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// stimulus, clock, reset and verdict for the plant step testbench
`timescale 1ns / 100ps
module tb_top
  import dtps_pkg::*;
();

  logic clk, rst;
  logic in_valid, in_ready, action, heater_on, intake_fan_on, stack_fan_on;
  logic [13:0] step_ms;
  logic [20:0] solar_level;
  logic out_valid, out_ready;
  logic signed [31:0] cabinet_temp_out, top_temp_out;
  logic [16:0] moisture_out;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [30:0] cfg_data;
  int mismatches, outstanding;
  int n_sent, n_done;
  bit calm_phase;
  logic [9:0] cur_speedup;

  dryer_thermal_plant_step u_top (.*);
  tb_plant_checker u_chk (.*);

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // completed output transactions
  always @(posedge clk)
    if (rst) n_done <= 0;
    else if (out_valid && out_ready) n_done <= n_done + 1;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_phase || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(logic act, logic [13:0] ms, logic heat, logic intake, logic stack,
                      logic [20:0] solar);
    int gap;
    in_valid <= 1'b1;
    action <= act;
    step_ms <= ms;
    heater_on <= heat;
    intake_fan_on <= intake;
    stack_fan_on <= stack;
    solar_level <= solar;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_done != n_sent) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_TIME_SPEEDUP) cur_speedup = val[9:0];
    @(posedge clk);
  endtask

  task automatic configure(logic [30:0] heat, logic [30:0] sol, logic [30:0] loss,
                           logic [30:0] fan, logic [30:0] dry, logic signed [22:0] amb,
                           logic [9:0] spd);
    write_reg(REG_HEATER_GAIN, heat);
    write_reg(REG_SOLAR_GAIN, sol);
    write_reg(REG_BASE_LOSS, loss);
    write_reg(REG_FAN_EXTRA_LOSS, fan);
    write_reg(REG_DRYING_RATE, dry);
    write_reg(REG_AMBIENT_TEMP, {8'd0, amb});
    write_reg(REG_TIME_SPEEDUP, {21'd0, spd});
    cfg_we <= 1'b0;
  endtask

  // random tick, length kept short when the speedup is large
  task automatic send_random();
    int max_ms;
    max_ms = 20000 / cur_speedup;
    if (max_ms > 10000) max_ms = 10000;
    send(1'($urandom_range(0, 99) < 6), 14'($urandom_range(0, max_ms)),
         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
         21'($urandom_range(0, 1048576)));
  endtask

  function automatic logic [30:0] rand_gain();
    case ($urandom_range(0, 3))
      0: return 31'd0;
      1: return 31'($urandom_range(0, 2000));
      2: return 31'($urandom_range(0, 400000));
      default: return 31'($urandom_range(0, 31'h7fffffff));
    endcase
  endfunction

  // receiver: random readiness, one long hold-off, some stretches fully ready
  initial begin
    bit held;
    held = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && n_sent >= 150) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (5000) @(posedge clk);
      end else if (calm_phase) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 2) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  initial begin
    #100_000_000;
    $display("FAIL dryer_thermal_plant_step");
    $finish;
  end

  initial begin
    in_valid = 1'b0;
    action = 1'b0;
    step_ms = '0;
    heater_on = 1'b0;
    intake_fan_on = 1'b0;
    stack_fan_on = 1'b0;
    solar_level = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    n_sent = 0;
    calm_phase = 0;
    cur_speedup = 10'd1;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values
    send(1'b0, 14'd10000, 1'b1, 1'b1, 1'b1, 21'd1048576);
    send(1'b0, 14'd3000, 1'b0, 1'b0, 1'b0, 21'd0);
    drain();

    // moderate plant, directed corner ticks
    configure(31'd131072, 31'd65536, 31'd655, 31'd1310, 31'd66, 23'sd1310720, 10'd1);
    send(1'b1, 14'd0, 1'b0, 1'b0, 1'b0, 21'd0);
    send(1'b0, 14'd0, 1'b1, 1'b1, 1'b1, 21'd1048576);
    send(1'b0, 14'd10000, 1'b1, 1'b0, 1'b0, 21'd0);
    send(1'b0, 14'd10000, 1'b1, 1'b1, 1'b1, 21'd1048576);
    send(1'b0, 14'd1, 1'b0, 1'b0, 1'b1, 21'd0);
    send(1'b0, 14'd5000, 1'b0, 1'b1, 1'b0, 21'd1048575);
    send(1'b0, 14'd5001, 1'b1, 1'b1, 1'b0, 21'd699050);
    send(1'b0, 14'd9999, 1'b0, 1'b0, 1'b1, 21'd1);
    send(1'b1, 14'd10000, 1'b1, 1'b1, 1'b1, 21'd1048576);
    send(1'b0, 14'd8192, 1'b1, 1'b1, 1'b1, 21'd524288);
    drain();

    // all gains, losses and the drying rate at maximum: saturation and moisture wiped out
    configure(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
              23'sd3932160, 10'd1000);
    send(1'b0, 14'd0, 1'b1, 1'b1, 1'b1, 21'd1048576);
    send(1'b0, 14'd1, 1'b1, 1'b1, 1'b0, 21'd1048576);
    send(1'b0, 14'd5, 1'b0, 1'b0, 1'b0, 21'd0);
    send(1'b0, 14'd12, 1'b1, 1'b1, 1'b1, 21'd1048576);
    send(1'b1, 14'd0, 1'b0, 1'b0, 1'b1, 21'd0);
    drain();

    // heater only with huge gain and no loss: climbs to the int32 limit
    configure(31'h7fffffff, 31'd0, 31'd0, 31'd0, 31'd655, -23'sd2621440, 10'd1);
    send(1'b0, 14'd10000, 1'b1, 1'b0, 1'b0, 21'd0);
    send(1'b0, 14'd10000, 1'b0, 1'b0, 1'b1, 21'd0);
    send(1'b1, 14'd0, 1'b0, 1'b0, 1'b0, 21'd0);
    send(1'b0, 14'd2000, 1'b0, 1'b0, 1'b0, 21'd0);
    drain();

    // random phases with fresh settings
    for (int ph = 0; ph < 8; ph++) begin
      calm_phase = (ph % 3 == 2);
      configure(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                23'(int'($urandom_range(0, 6553600)) - 2621440),
                ($urandom_range(0, 1) != 0) ? 10'd1 : 10'($urandom_range(1, 1000)));
      repeat (72) send_random();
      drain();
    end

    if (mismatches == 0 && outstanding == 0)
      $display("PASS dryer_thermal_plant_step");
    else
      $display("FAIL dryer_thermal_plant_step");
    $finish;
  end

endmodule
